@@ design/gts_pkg.sv @@
// ============================================================================
// gts_pkg - shared types and constants of the pan/tilt gaze angle solver
// Angle constants, CORDIC arctangent table, status codes, item and config types.
// ============================================================================
package gts_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int NORM_STAGES  = 7;
  localparam int ATAN_LAT     = 1 + NORM_STAGES + CORDIC_STEPS;
  localparam int SQRT_LAT     = 32;
  // back pipeline taps (index into the stage array)
  localparam int SQRT_TAP     = 5;
  localparam int ATAN_TAP     = SQRT_TAP + SQRT_LAT;
  localparam int LAST_TAP     = ATAN_TAP + ATAN_LAT;
  localparam int NSTG         = LAST_TAP + 1;

  localparam int QDEPTH = 2;

  localparam logic signed [24:0] ANG_PI     = 25'sd3294199;
  localparam logic signed [26:0] ANG_TWO_PI = 27'sd6588398;

  localparam logic [24:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'd823550, 25'd486170, 25'd256879, 25'd130396, 25'd65451, 25'd32757,
    25'd16383, 25'd8192, 25'd4096, 25'd2048, 25'd1024, 25'd512, 25'd256,
    25'd128, 25'd64, 25'd32, 25'd16, 25'd8, 25'd4, 25'd2
  };

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_YAW_ZERO      = 3'd1,
    ST_YAW_UNREACH   = 3'd2,
    ST_PITCH_ZERO    = 3'd3,
    ST_PITCH_UNREACH = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    CFG_YAW_TERM   = 4'd0,
    CFG_PITCH_TERM = 4'd1,
    CFG_SHIFT_X    = 4'd2,
    CFG_SHIFT_Y    = 4'd3,
    CFG_SHIFT_Z    = 4'd4,
    CFG_ROW_A      = 4'd5,
    CFG_ROW_B      = 4'd6,
    CFG_ROW_C      = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] k_yaw;
    logic signed [31:0] k_pitch;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic [62:0]        row_a;
    logic [62:0]        row_b;
    logic [62:0]        row_c;
  } cfg_t;

  typedef struct packed {
    logic               zero;
    logic               gx_neg;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
  } item_t;

endpackage

@@ design/gts_front.sv @@
// ============================================================================
// gts_front - input side of the solver
// Accepts gaze words, flags zero-length points and negative x, and queues them.
// ============================================================================
module gts_front import gts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] gaze_x_i,
  input  logic signed [31:0] gaze_y_i,
  input  logic signed [31:0] gaze_z_i,
  output logic               q_valid_o,
  output item_t              q_item_o
);

  localparam int PW = $clog2(QDEPTH);

  item_t          mem_q [QDEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]    cnt_q, cnt_d;
  logic           push, pop;
  item_t          item_in;

  assign busy_o    = (cnt_q == (PW+1)'(QDEPTH));
  assign push      = start_i && !busy_o;
  // back end never stalls, so the head word leaves as soon as it is there
  assign pop       = (cnt_q != '0);
  assign q_valid_o = pop;
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    item_in.gx     = gaze_x_i;
    item_in.gy     = gaze_y_i;
    item_in.gz     = gaze_z_i;
    item_in.zero   = (gaze_x_i == '0) && (gaze_y_i == '0) && (gaze_z_i == '0);
    item_in.gx_neg = gaze_x_i[31];
    wr_d  = push ? PW'((wr_q + 1'b1) % QDEPTH) : wr_q;
    rd_d  = pop  ? PW'((rd_q + 1'b1) % QDEPTH) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDEPTH))
    else $error("queue count past depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue lost a word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(1))
    else $error("queue backed up although the back end drains every cycle");

endmodule

@@ design/gts_sqrt.sv @@
// ============================================================================
// gts_sqrt - pipelined floor square root
// 64-bit radicand, one result bit per stage, 32 stages.
// ============================================================================
module gts_sqrt import gts_pkg::*; (
  input  logic        clk_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [63:0] rem_q  [SQRT_LAT];
  logic [31:0] root_q [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    localparam int B = SQRT_LAT - 1 - i;
    logic [63:0] rem_in, rem_d;
    logic [31:0] root_in, root_d;
    logic [65:0] trial;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    always_comb begin
      trial  = ({34'd0, root_in} << (B + 1)) | (66'd1 << (2 * B));
      rem_d  = rem_in;
      root_d = root_in;
      if ({2'b00, rem_in} >= trial) begin
        rem_d  = rem_in - trial[63:0];
        root_d = root_in | (32'd1 << B);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

@@ design/gts_atan2.sv @@
// ============================================================================
// gts_atan2 - pipelined CORDIC arctangent
// Quadrant fold, staged normalize to 2^40, then 20 vectoring steps. Q4.20 out.
// ============================================================================
module gts_atan2 import gts_pkg::*; (
  input  logic               clk_i,
  input  logic signed [33:0] y_i,
  input  logic signed [33:0] x_i,
  output logic signed [24:0] ang_o
);

  localparam int W = 48;

  logic signed [W-1:0] x_q [ATAN_LAT];
  logic signed [W-1:0] y_q [ATAN_LAT];
  logic signed [24:0]  z_q [ATAN_LAT];
  logic                zf_q [ATAN_LAT];

  // fold left half-plane onto the right, start at +/- pi
  always_ff @(posedge clk_i) begin
    zf_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i[33]) begin
      x_q[0] <= -W'(x_i);
      y_q[0] <= -W'(y_i);
      z_q[0] <= y_i[33] ? -ANG_PI : ANG_PI;
    end else begin
      x_q[0] <= W'(x_i);
      y_q[0] <= W'(y_i);
      z_q[0] <= '0;
    end
  end

  for (genvar s = 1; s < ATAN_LAT; s++) begin : g_stage
    if (s <= NORM_STAGES) begin : g_norm
      // greedy binary shift, last stage pushes one magnitude past 2^40
      localparam int SH   = (s == NORM_STAGES) ? 1 : (32 >> (s - 1));
      localparam int LEXP = (s == NORM_STAGES) ? 40 : 40 - SH;
      localparam logic signed [W-1:0] LIM = W'(64'd1 << LEXP);
      logic fits;
      assign fits = (x_q[s-1] < LIM) && (x_q[s-1] > -LIM) &&
                    (y_q[s-1] < LIM) && (y_q[s-1] > -LIM);
      always_ff @(posedge clk_i) begin
        x_q[s]  <= fits ? (x_q[s-1] <<< SH) : x_q[s-1];
        y_q[s]  <= fits ? (y_q[s-1] <<< SH) : y_q[s-1];
        z_q[s]  <= z_q[s-1];
        zf_q[s] <= zf_q[s-1];
      end
    end else begin : g_cordic
      localparam int I = s - NORM_STAGES - 1;
      logic signed [W-1:0] xs, ys;
      assign xs = x_q[s-1] >>> I;
      assign ys = y_q[s-1] >>> I;
      always_ff @(posedge clk_i) begin
        zf_q[s] <= zf_q[s-1];
        if (!y_q[s-1][W-1]) begin
          x_q[s] <= x_q[s-1] + ys;
          y_q[s] <= y_q[s-1] - xs;
          z_q[s] <= z_q[s-1] + $signed(ATAN_TAB[I]);
        end else begin
          x_q[s] <= x_q[s-1] - ys;
          y_q[s] <= y_q[s-1] + xs;
          z_q[s] <= z_q[s-1] - $signed(ATAN_TAB[I]);
        end
      end
    end
  end

  assign ang_o = zf_q[ATAN_LAT-1] ? '0 : z_q[ATAN_LAT-1];

endmodule

@@ design/gts_back.sv @@
// ============================================================================
// gts_back - execution pipeline of the solver
// Squares, pitch-frame transform, reach checks, three roots, four arctangents.
// ============================================================================
module gts_back import gts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  item_t              in_item_i,
  input  cfg_t               cfg_i,
  output logic               res_valid_o,
  output logic signed [23:0] pan_o,
  output logic signed [23:0] tilt_o,
  output logic [2:0]         status_o
);

  typedef struct packed {
    logic               zero;
    logic               gx_neg;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gpz;
    status_e            yaw_st;
    status_e            pitch_st;
  } car_t;

  function automatic logic [63:0] square(logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return 64'(m) * 64'(m);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [36:0] v);
    if (v > 37'sd2147483647)       return 32'sh7fffffff;
    else if (v < -37'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  logic [NSTG-1:0]     vld_q;
  car_t                car_q [NSTG];
  car_t                car_d [NSTG];

  logic [63:0]         sqg_q [3];
  logic signed [52:0]  prod_q [3][3];
  logic [63:0]         kysq_q, kpsq_q;
  logic [63:0]         s_q;
  logic signed [35:0]  acc_q [3];
  logic signed [31:0]  gp_q [3];
  logic signed [31:0]  gp_d [3];
  logic [63:0]         yrad_q [4];
  logic [63:0]         sqgp_q [3];
  logic [63:0]         sp_q, h2_q, h2b_q, prad_q;
  status_e             yaw_st_d, pitch_st_d;
  logic [62:0]         rows [3];
  logic signed [31:0]  shifts [3];
  logic signed [31:0]  g_in [3];

  assign rows   = '{cfg_i.row_a, cfg_i.row_b, cfg_i.row_c};
  assign shifts = '{cfg_i.shift_x, cfg_i.shift_y, cfg_i.shift_z};
  assign g_in   = '{in_item_i.gx, in_item_i.gy, in_item_i.gz};

  // stage 1: squares and matrix products
  always_ff @(posedge clk_i) begin
    kysq_q <= square(cfg_i.k_yaw);
    kpsq_q <= square(cfg_i.k_pitch);
    for (int i = 0; i < 3; i++) begin
      sqg_q[i] <= square(g_in[i]);
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= $signed(rows[i][21*j +: 21]) * g_in[j];
      end
    end
  end

  // stage 2: sum of squares, rounded row sums
  always_ff @(posedge clk_i) begin
    logic signed [54:0] acc;
    s_q <= sqg_q[0] + sqg_q[1] + sqg_q[2];
    for (int i = 0; i < 3; i++) begin
      acc = 55'(prod_q[i][0]) + 55'(prod_q[i][1]) + 55'(prod_q[i][2]) + 55'sd262144;
      acc_q[i] <= 36'(acc >>> 19);
    end
  end

  // stage 3: yaw checks, pitch-frame point; stage 6: pitch checks
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gp_d[i] = sat32(37'(acc_q[i]) - 37'(shifts[i]));
    end
    priority if (car_q[1].zero) yaw_st_d = ST_YAW_ZERO;
    else if (kysq_q > s_q)      yaw_st_d = ST_YAW_UNREACH;
    else                        yaw_st_d = ST_OK;
    priority if (sp_q == '0)    pitch_st_d = ST_PITCH_ZERO;
    else if (kpsq_q > sp_q)     pitch_st_d = ST_PITCH_UNREACH;
    else                        pitch_st_d = ST_OK;
  end

  always_ff @(posedge clk_i) begin
    gp_q      <= gp_d;
    yrad_q[0] <= s_q - kysq_q;
    for (int i = 1; i < 4; i++) yrad_q[i] <= yrad_q[i-1];
    for (int i = 0; i < 3; i++) sqgp_q[i] <= square(gp_q[i]);   // stage 4
    sp_q   <= sqgp_q[0] + sqgp_q[1] + sqgp_q[2];               // stage 5
    h2_q   <= sqgp_q[0] + sqgp_q[1];
    prad_q <= sp_q - kpsq_q;                                    // stage 6
    h2b_q  <= h2_q;
  end

  // side words ride alongside the arithmetic
  always_comb begin
    car_d[0].zero     = in_item_i.zero;
    car_d[0].gx_neg   = in_item_i.gx_neg;
    car_d[0].gx       = in_item_i.gx;
    car_d[0].gy       = in_item_i.gy;
    car_d[0].gpz      = '0;
    car_d[0].yaw_st   = ST_OK;
    car_d[0].pitch_st = ST_OK;
    for (int k = 1; k < NSTG; k++) car_d[k] = car_q[k-1];
    car_d[2].yaw_st   = yaw_st_d;
    car_d[2].gpz      = gp_d[2];
    car_d[SQRT_TAP].pitch_st = pitch_st_d;
  end

  always_ff @(posedge clk_i) begin
    car_q <= car_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  logic [31:0]        r_yaw, r_h, r_pitch;
  logic signed [24:0] a_yaw, a_asy, a_tilt, a_asp;

  gts_sqrt u_sqrt_yaw   (.clk_i, .rad_i(yrad_q[3]), .root_o(r_yaw));
  gts_sqrt u_sqrt_horiz (.clk_i, .rad_i(h2b_q),     .root_o(r_h));
  gts_sqrt u_sqrt_pitch (.clk_i, .rad_i(prad_q),    .root_o(r_pitch));

  gts_atan2 u_atan_yaw (.clk_i, .y_i(34'(car_q[ATAN_TAP].gy)),
                        .x_i(34'(car_q[ATAN_TAP].gx)), .ang_o(a_yaw));
  gts_atan2 u_asin_yaw (.clk_i, .y_i(34'(cfg_i.k_yaw)),
                        .x_i({2'b00, r_yaw}), .ang_o(a_asy));
  gts_atan2 u_atan_tilt (.clk_i, .y_i(34'(car_q[ATAN_TAP].gpz)),
                         .x_i({2'b00, r_h}), .ang_o(a_tilt));
  gts_atan2 u_asin_pitch (.clk_i, .y_i(34'(cfg_i.k_pitch)),
                          .x_i({2'b00, r_pitch}), .ang_o(a_asp));

  logic signed [26:0] pan_d, tilt_d;
  status_e            st_d;
  car_t               fin;

  assign fin = car_q[LAST_TAP];

  always_comb begin
    pan_d  = 27'(a_yaw) - 27'(a_asy);
    if (fin.gx_neg && pan_d > 27'sd0) pan_d = pan_d - ANG_TWO_PI;
    tilt_d = 27'(a_tilt) - 27'(a_asp);
    st_d   = (fin.yaw_st != ST_OK) ? fin.yaw_st : fin.pitch_st;
    if (st_d != ST_OK) begin
      pan_d  = '0;
      tilt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= vld_q[LAST_TAP];
    end
  end

  always_ff @(posedge clk_i) begin
    pan_o    <= pan_d[23:0];
    tilt_o   <= tilt_d[23:0];
    status_o <= st_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_OK |-> pan_o == '0 && tilt_o == '0)
    else $error("angles not cleared on a failed point");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_item_i.zero |-> ##3 car_q[2].yaw_st == ST_YAW_ZERO)
    else $error("zero point not flagged");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> status_o == ST_OK || status_o == ST_YAW_ZERO ||
      status_o == ST_YAW_UNREACH || status_o == ST_PITCH_ZERO ||
      status_o == ST_PITCH_UNREACH)
    else $error("status code out of range");

endmodule

@@ design/pan_tilt_gaze_angle_solver.sv @@
// ============================================================================
// pan_tilt_gaze_angle_solver - pan and tilt joint angles for a gaze point
// Front queue plus a fixed-latency back pipeline of roots and CORDIC units.
// ============================================================================
// channel   direction  handshake                 payload
// command   in         start_i, busy_o           gaze_x_i, gaze_y_i, gaze_z_i
// result    out        result_valid_o (strobe)   pan_angle_o, tilt_angle_o, status_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word per cycle sustained; between the acceptance of a start and its result
// strobe lie the queue register, the arithmetic stages, the 32-stage root units
// and the 28-stage arctangent units in series, and the output register.
// rst_ni is asynchronous; it clears the queue and pipeline valids and sets config to its reset values.
// busy_o only rises if the queue ever fills; results are strobed for one cycle.
// ============================================================================
module pan_tilt_gaze_angle_solver import gts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] gaze_x_i,
  input  logic signed [31:0] gaze_y_i,
  input  logic signed [31:0] gaze_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [23:0] pan_angle_o,
  output logic signed [23:0] tilt_angle_o,
  output logic [2:0]         status_o
);

  cfg_t  cfg_q;
  logic  q_valid;
  item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_yaw   <= '0;
      cfg_q.k_pitch <= '0;
      cfg_q.shift_x <= '0;
      cfg_q.shift_y <= '0;
      cfg_q.shift_z <= '0;
      cfg_q.row_a   <= 63'd274877906944;
      cfg_q.row_b   <= 63'd1073741824;
      cfg_q.row_c   <= 63'd524288;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_YAW_TERM:   cfg_q.k_yaw   <= cfg_data_i[31:0];
        CFG_PITCH_TERM: cfg_q.k_pitch <= cfg_data_i[31:0];
        CFG_SHIFT_X:    cfg_q.shift_x <= cfg_data_i[31:0];
        CFG_SHIFT_Y:    cfg_q.shift_y <= cfg_data_i[31:0];
        CFG_SHIFT_Z:    cfg_q.shift_z <= cfg_data_i[31:0];
        CFG_ROW_A:      cfg_q.row_a   <= cfg_data_i[62:0];
        CFG_ROW_B:      cfg_q.row_b   <= cfg_data_i[62:0];
        CFG_ROW_C:      cfg_q.row_c   <= cfg_data_i[62:0];
        default: ;  // unmapped index, word dropped
      endcase
    end
  end

  gts_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .gaze_x_i, .gaze_y_i, .gaze_z_i,
    .q_valid_o(q_valid), .q_item_o(q_item)
  );

  gts_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_item_i(q_item), .cfg_i(cfg_q),
    .res_valid_o(result_valid_o), .pan_o(pan_angle_o),
    .tilt_o(tilt_angle_o), .status_o
  );

endmodule
